// ----- hdl/igbt_pkg.sv -----
package igbt_pkg;

    localparam int SIZE_BITS   = 12;
    localparam int AREA_BITS   = 2 * SIZE_BITS;
    localparam int UNION_BITS  = AREA_BITS + 1;
    localparam int THR_BITS    = 8;
    localparam int FRAC_BITS   = 8;
    localparam int PROD_BITS   = THR_BITS + UNION_BITS;
    localparam int OBJ_ID_BITS = 16;

    localparam logic [THR_BITS-1:0] THR_RESET = 8'd128;

    typedef struct packed {
        logic busy;
        logic valid;
        logic hit;
    } match_stat_t;

endpackage

// ----- hdl/igbt_store.sv -----
module igbt_store #(
    parameter int WIDTH = 74,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/igbt_match.sv -----
module igbt_match #(
    parameter int COORD_BITS = 13,
    parameter int ID_BITS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                launch,
    input  logic [igbt_pkg::THR_BITS-1:0]       thr,
    input  logic signed [COORD_BITS-1:0]        qx,
    input  logic signed [COORD_BITS-1:0]        qy,
    input  logic [igbt_pkg::SIZE_BITS-1:0]      qw,
    input  logic [igbt_pkg::SIZE_BITS-1:0]      qh,
    input  logic signed [COORD_BITS-1:0]        ex,
    input  logic signed [COORD_BITS-1:0]        ey,
    input  logic [igbt_pkg::SIZE_BITS-1:0]      ew,
    input  logic [igbt_pkg::SIZE_BITS-1:0]      eh,
    input  logic [ID_BITS-1:0]                  eid,
    output igbt_pkg::match_stat_t               stat,
    output logic [ID_BITS-1:0]                  hit_id
);

    localparam int SB = igbt_pkg::SIZE_BITS;
    localparam int EW = ((COORD_BITS > SB) ? COORD_BITS : SB + 1) + 1;

    logic signed [EW-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic signed [EW-1:0] lo_x, hi_x, lo_y, hi_y, dx, dy;
    logic [SB-1:0]        dx_clamp, dy_clamp;

    logic                               v0_reg, va_reg, vb_reg, vc_reg;
    logic [SB-1:0]                      dx_reg, dy_reg, ew_a_reg, eh_a_reg;
    logic [ID_BITS-1:0]                 id_a_reg, id_b_reg, id_c_reg;
    logic [igbt_pkg::AREA_BITS-1:0]     area_a_reg, inter_b_reg, area_b_reg, inter_c_reg;
    logic [igbt_pkg::UNION_BITS-1:0]    union_reg;
    logic [igbt_pkg::PROD_BITS-1:0]     prod, scaled;

    always_comb
    begin
        ax0  = EW'(qx);
        ay0  = EW'(qy);
        bx0  = EW'(ex);
        by0  = EW'(ey);
        ax1  = ax0 + EW'(qw);
        ay1  = ay0 + EW'(qh);
        bx1  = bx0 + EW'(ew);
        by1  = by0 + EW'(eh);
        lo_x = (ax0 > bx0) ? ax0 : bx0;
        lo_y = (ay0 > by0) ? ay0 : by0;
        hi_x = (ax1 < bx1) ? ax1 : bx1;
        hi_y = (ay1 < by1) ? ay1 : by1;
        dx   = hi_x - lo_x;
        dy   = hi_y - lo_y;
        dx_clamp = dx[EW-1] ? '0 : dx[SB-1:0];
        dy_clamp = dy[EW-1] ? '0 : dy[SB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= launch;
            va_reg <= v0_reg;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_clamp;
        dy_reg      <= dy_clamp;
        ew_a_reg    <= ew;
        eh_a_reg    <= eh;
        id_a_reg    <= eid;
        area_a_reg  <= igbt_pkg::AREA_BITS'(qw) * igbt_pkg::AREA_BITS'(qh);
        inter_b_reg <= igbt_pkg::AREA_BITS'(dx_reg) * igbt_pkg::AREA_BITS'(dy_reg);
        area_b_reg  <= igbt_pkg::AREA_BITS'(ew_a_reg) * igbt_pkg::AREA_BITS'(eh_a_reg);
        id_b_reg    <= id_a_reg;
        union_reg   <= igbt_pkg::UNION_BITS'(area_a_reg)
                     + igbt_pkg::UNION_BITS'(area_b_reg)
                     - igbt_pkg::UNION_BITS'(inter_b_reg);
        inter_c_reg <= inter_b_reg;
        id_c_reg    <= id_b_reg;
    end

    assign prod   = igbt_pkg::PROD_BITS'(thr) * igbt_pkg::PROD_BITS'(union_reg);
    assign scaled = igbt_pkg::PROD_BITS'({inter_c_reg, igbt_pkg::FRAC_BITS'(0)});

    assign stat.busy  = v0_reg | va_reg | vb_reg | vc_reg;
    assign stat.valid = vc_reg;
    assign stat.hit   = (union_reg != '0) && (scaled > prod);
    assign hit_id     = id_c_reg;

endmodule

// ----- hdl/iou_greedy_box_tracker.sv -----
// Greedy IoU tracker: each box is compared in stored order with the boxes kept
// from the previous frame and takes the ID of the first one whose IoU exceeds
// iou_threshold/256 (256*intersection > threshold*union; a zero union never
// matches), else a fresh ID from a wrapping counter. Boxes are kept in a
// two-bank memory of 2*MAX_BOXES entries; last_in_frame swaps the banks. Boxes
// past MAX_BOXES in a frame get IDs but are not kept (store_overflow). An item
// with a box scans the previous frame's kept boxes: the memory's single read
// port delivers one stored box a cycle into a four-stage compare pipeline. A
// bare item gives no ID. New items stall until a result is loaded; it then
// waits in the output register while the next item is taken.
module iou_greedy_box_tracker #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 13,
    parameter int ID_BITS    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [igbt_pkg::THR_BITS-1:0]        cfg_data,
    input  logic                                 box_valid,
    output logic                                 box_stall,
    input  logic                                 has_box,
    input  logic signed [COORD_BITS-1:0]         box_x,
    input  logic signed [COORD_BITS-1:0]         box_y,
    input  logic [igbt_pkg::SIZE_BITS-1:0]       box_width,
    input  logic [igbt_pkg::SIZE_BITS-1:0]       box_height,
    input  logic                                 last_in_frame,
    output logic                                 id_valid,
    input  logic                                 id_stall,
    output logic [igbt_pkg::OBJ_ID_BITS-1:0]     object_id,
    output logic                                 is_new,
    output logic                                 store_overflow
);

    localparam int SB      = igbt_pkg::SIZE_BITS;
    localparam int CW      = $clog2(MAX_BOXES + 1);
    localparam int IW      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int DEPTH   = 2 * MAX_BOXES;
    localparam int AW      = $clog2(DEPTH);
    localparam int ENTRY_W = 2 * COORD_BITS + 2 * SB + ID_BITS;
    localparam int H_LSB   = ID_BITS;
    localparam int W_LSB   = H_LSB + SB;
    localparam int Y_LSB   = W_LSB + SB;
    localparam int X_LSB   = Y_LSB + COORD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic                           bank_reg, bank_next;
    logic [CW-1:0]                  prev_cnt_reg, prev_cnt_next;
    logic [CW-1:0]                  cur_cnt_reg, cur_cnt_next;
    logic [CW-1:0]                  issue_cnt_reg, issue_cnt_next;
    logic [ID_BITS-1:0]             next_id_reg, next_id_next;
    logic                           found_reg, found_next;
    logic                           id_valid_reg, id_valid_next;
    logic [igbt_pkg::THR_BITS-1:0]  thr_reg;

    logic [ID_BITS-1:0]             found_id_reg;
    logic signed [COORD_BITS-1:0]   q_x_reg, q_y_reg;
    logic [SB-1:0]                  q_w_reg, q_h_reg;
    logic                           q_last_reg;
    logic [igbt_pkg::OBJ_ID_BITS-1:0] object_id_reg;
    logic                           is_new_reg, overflow_reg;

    logic                           accept, launch, out_free, load, full;
    logic [ID_BITS-1:0]             win_id;
    logic [AW-1:0]                  rd_addr, wr_addr, prev_base, cur_base;
    logic [ENTRY_W-1:0]             rd_data, wr_data;
    igbt_pkg::match_stat_t          stat;
    logic [ID_BITS-1:0]             hit_id;

    assign box_stall = (state_reg != ST_IDLE);
    assign accept    = box_valid & ~box_stall;
    assign launch    = (state_reg == ST_SCAN) && (issue_cnt_reg != prev_cnt_reg);
    assign out_free  = ~id_valid_reg | ~id_stall;
    assign load      = (state_reg == ST_DONE) && out_free;
    assign full      = (cur_cnt_reg == CW'(MAX_BOXES));
    assign win_id    = found_reg ? found_id_reg : next_id_reg;

    assign prev_base = bank_reg ? '0 : AW'(MAX_BOXES);
    assign cur_base  = bank_reg ? AW'(MAX_BOXES) : '0;
    assign rd_addr   = prev_base + AW'(issue_cnt_reg[IW-1:0]);
    assign wr_addr   = cur_base + AW'(cur_cnt_reg[IW-1:0]);
    assign wr_data   = {q_x_reg, q_y_reg, q_w_reg, q_h_reg, win_id};

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        prev_cnt_next  = prev_cnt_reg;
        cur_cnt_next   = cur_cnt_reg;
        issue_cnt_next = issue_cnt_reg;
        next_id_next   = next_id_reg;
        found_next     = found_reg;
        id_valid_next  = id_valid_reg & id_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_box)
                    begin
                        state_next     = ST_SCAN;
                        issue_cnt_next = '0;
                        found_next     = 1'b0;
                    end
                    else if (last_in_frame)
                    begin
                        bank_next     = ~bank_reg;
                        prev_cnt_next = cur_cnt_reg;
                        cur_cnt_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (launch)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (stat.valid && stat.hit && !found_reg)
                begin
                    found_next = 1'b1;
                end
                if (!launch && !stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    id_valid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (!found_reg)
                    begin
                        next_id_next = next_id_reg + 1'b1;
                    end
                    if (q_last_reg)
                    begin
                        bank_next     = ~bank_reg;
                        prev_cnt_next = full ? cur_cnt_reg : cur_cnt_reg + 1'b1;
                        cur_cnt_next  = '0;
                    end
                    else if (!full)
                    begin
                        cur_cnt_next = cur_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            prev_cnt_reg  <= '0;
            cur_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            next_id_reg   <= '0;
            found_reg     <= 1'b0;
            id_valid_reg  <= 1'b0;
            thr_reg       <= igbt_pkg::THR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            prev_cnt_reg  <= prev_cnt_next;
            cur_cnt_reg   <= cur_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            next_id_reg   <= next_id_next;
            found_reg     <= found_next;
            id_valid_reg  <= id_valid_next;
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_x_reg    <= box_x;
            q_y_reg    <= box_y;
            q_w_reg    <= box_width;
            q_h_reg    <= box_height;
            q_last_reg <= last_in_frame;
        end
        if ((state_reg == ST_SCAN) && stat.valid && stat.hit && !found_reg)
        begin
            found_id_reg <= hit_id;
        end
        if (load)
        begin
            object_id_reg <= igbt_pkg::OBJ_ID_BITS'(win_id);
            is_new_reg    <= ~found_reg;
            overflow_reg  <= full;
        end
    end

    igbt_store #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (load & ~full),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (launch),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    igbt_match #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_match (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .thr    (thr_reg),
        .qx     (q_x_reg),
        .qy     (q_y_reg),
        .qw     (q_w_reg),
        .qh     (q_h_reg),
        .ex     (rd_data[X_LSB +: COORD_BITS]),
        .ey     (rd_data[Y_LSB +: COORD_BITS]),
        .ew     (rd_data[W_LSB +: SB]),
        .eh     (rd_data[H_LSB +: SB]),
        .eid    (rd_data[ID_BITS-1:0]),
        .stat   (stat),
        .hit_id (hit_id)
    );

    assign id_valid       = id_valid_reg;
    assign object_id      = object_id_reg;
    assign is_new         = is_new_reg;
    assign store_overflow = overflow_reg;

`ifndef SYNTHESIS
    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !stat.busy)
        else $error("compare pipeline still busy at result time");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= prev_cnt_reg))
        else $error("scan read past previous frame count");

    a_new_id_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !found_reg) |=> (next_id_reg == ID_BITS'($past(next_id_reg) + 1'b1)))
        else $error("fresh ID issued without advancing counter");
`endif

endmodule
